[rtl/led_matrix_scroll_scanner_unit_macros.svh]
// ----------------------------------------------------------------------------
// led matrix scroll scanner assertion macros
// shared concurrent assertion forms, clocked on i_clk, quiet during reset
// ----------------------------------------------------------------------------
`ifndef LED_MATRIX_SCROLL_SCANNER_UNIT_MACROS_SVH
`define LED_MATRIX_SCROLL_SCANNER_UNIT_MACROS_SVH

// same-cycle implication
`define LMSS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LMSS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/lmss_pkg.sv]
// ----------------------------------------------------------------------------
// lmss_pkg
// shared constants, tables and helpers of the led matrix scroll scanner
// ----------------------------------------------------------------------------
package lmss_pkg;

    localparam int FRAME_DEPTH_DEF = 128;
    localparam int ROWS            = 8;
    localparam int ROW_W           = 3;
    localparam int COL_W           = 16;
    localparam int LEN_W           = 9;
    localparam int TICK_W          = 17;
    localparam int BIT_IDX_W       = 6;
    localparam int WORD_W          = 56;
    localparam int SCAN_SPAN       = 24;
    localparam int COL_STEP        = 8;

    localparam logic [TICK_W-1:0] SHIFT_TICKS = 17'd112;

    localparam logic [COL_W-1:0] MASK_ONE = 16'h00ff;
    localparam logic [COL_W-1:0] MASK_ALL = 16'hffff;

    localparam logic [7:0]  RST_FRAME_LEN   = 8'd128;
    localparam logic [15:0] RST_LONG_DWELL  = 16'd1000;
    localparam logic [15:0] RST_SHORT_DWELL = 16'd100;
    localparam logic [7:0]  RST_REPEAT      = 8'd8;

    // register indexes on the configuration port
    typedef enum logic [1:0] {
        REG_FRAME_LEN   = 2'd0,
        REG_LONG_DWELL  = 2'd1,
        REG_SHORT_DWELL = 2'd2,
        REG_REPEAT      = 2'd3
    } t_reg_idx;

    localparam logic [3:0] BIT_DEST [COL_W] = '{
        4'd9, 4'd11, 4'd13, 4'd15, 4'd1, 4'd3, 4'd5, 4'd7,
        4'd8, 4'd10, 4'd12, 4'd14, 4'd0, 4'd2, 4'd4, 4'd6
    };

    localparam logic [2:0] ANODE_BIT [ROWS] = '{
        3'd6, 3'd4, 3'd2, 3'd0, 3'd7, 3'd5, 3'd3, 3'd1
    };

    // board wiring of one column word, active low
    function automatic logic [COL_W-1:0] permute(input logic [COL_W-1:0] x);
        logic [COL_W-1:0] r;
        r = '0;
        for (int b = 0; b < COL_W; b++) begin
            r[BIT_DEST[b]] = x[b];
        end
        return ~r;
    endfunction

    function automatic logic [7:0] anode(input logic [ROW_W-1:0] row);
        logic [7:0] a;
        a = '0;
        a[ANODE_BIT[row]] = 1'b1;
        return a;
    endfunction

endpackage

[rtl/lmss_frame_store.sv]
// ----------------------------------------------------------------------------
// lmss_frame_store
// column word memory, one write and two registered reads per cycle,
// entries never written read as zero
// ----------------------------------------------------------------------------
module lmss_frame_store #(
    parameter int FRAME_DEPTH = lmss_pkg::FRAME_DEPTH_DEF,
    parameter int AW          = $clog2(FRAME_DEPTH)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_we,
    input  logic [AW-1:0]              i_waddr,
    input  logic [lmss_pkg::COL_W-1:0] i_wdata,
    input  logic [AW-1:0]              i_raddr0,
    input  logic [AW-1:0]              i_raddr1,
    output logic [lmss_pkg::COL_W-1:0] o_rdata0,
    output logic [lmss_pkg::COL_W-1:0] o_rdata1
);

    logic [lmss_pkg::COL_W-1:0] r_mem [FRAME_DEPTH];
    logic [FRAME_DEPTH-1:0]     r_vld;
    logic [lmss_pkg::COL_W-1:0] r_d0;
    logic [lmss_pkg::COL_W-1:0] r_d1;
    logic                       r_v0;
    logic                       r_v1;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_d0 <= r_mem[i_raddr0];
        r_d1 <= r_mem[i_raddr1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_v0  <= 1'b0;
            r_v1  <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            r_v0 <= r_vld[i_raddr0];
            r_v1 <= r_vld[i_raddr1];
        end
    end

    assign o_rdata0 = r_v0 ? r_d0 : '0;
    assign o_rdata1 = r_v1 ? r_d1 : '0;

endmodule

[rtl/led_matrix_scroll_scanner_unit.sv]
// ----------------------------------------------------------------------------
// led_matrix_scroll_scanner_unit
// scrolling red/green led matrix scanner driving a shift register chain
// ----------------------------------------------------------------------------
// Each tick transaction on the input stream produces one pin-level result
// (serial data, shift clock, latch), registered in the first stage and then
// in the output register; a column write produces none. Ticks and writes are
// both taken at one per clock, but when a stalled output holds a result and
// the first stage holds a tick, the next transaction waits. At the first tick
// of every send the three column words are fetched from the frame store: two
// on its read ports in that cycle, the third on the next cycle, and the pin
// sequence continues from registered column words. The frame store has
// per-entry valid bits, so reset takes effect at once with no clearing pass.
`include "led_matrix_scroll_scanner_unit_macros.svh"

module led_matrix_scroll_scanner_unit #(
    parameter int FRAME_DEPTH = lmss_pkg::FRAME_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // write_index[6:0], write_value[22:7], zero
    input  logic        i_s_axis_tuser,   // kind: 0 tick, 1 column write
    // result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // serial_data[0], shift_clock[1], latch_clock[2]
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = $clog2(FRAME_DEPTH);

    // configuration registers
    logic [7:0]  r_frame_len;
    logic [15:0] r_long_dwell;
    logic [15:0] r_short_dwell;
    logic [7:0]  r_repeat;

    // scan counters
    logic [lmss_pkg::TICK_W-1:0] r_tick;
    logic                        r_phase;
    logic [lmss_pkg::ROW_W-1:0]  r_row;
    logic [7:0]                  r_rep_idx;
    logic [AW-1:0]               r_offset;

    // column fetch
    logic                        r_ld1;
    logic                        r_ld2;
    logic                        r_ld_full;
    logic [AW-1:0]               r_addr_c;
    logic [lmss_pkg::COL_W-1:0]  r_col_a;
    logic [lmss_pkg::COL_W-1:0]  r_col_b;
    logic [lmss_pkg::COL_W-1:0]  r_col_c;
    logic [7:0]                  r_anode;

    // pipeline
    logic                           r_s1_valid;
    logic                           r_s1_shift;
    logic                           r_s1_sclk;
    logic                           r_s1_latch;
    logic [lmss_pkg::BIT_IDX_W-1:0] r_s1_bit;
    logic                           r_out_valid;
    logic [2:0]                     r_out_data;

    logic                        cfg_wr;
    logic                        in_acc;
    logic                        tick_acc;
    logic                        tick_load;
    logic                        wr_acc;
    logic                        s1_adv;
    logic [6:0]                  wr_index;
    logic [lmss_pkg::COL_W-1:0]  wr_value;
    logic [AW-1:0]               addr_a;
    logic [AW-1:0]               addr_b;
    logic [AW-1:0]               addr_c;
    logic [AW-1:0]               raddr0;
    logic [lmss_pkg::COL_W-1:0]  rdata0;
    logic [lmss_pkg::COL_W-1:0]  rdata1;
    logic [lmss_pkg::COL_W-1:0]  mask;
    logic [lmss_pkg::COL_W-1:0]  col_a_cur;
    logic [lmss_pkg::WORD_W-1:0] word;
    logic                        s1_data;
    logic [15:0]                 dwell;
    logic                        send_end;
    logic [lmss_pkg::LEN_W-1:0]  len;
    logic [lmss_pkg::LEN_W-1:0]  last;
    logic [lmss_pkg::LEN_W-1:0]  offset_inc;
    logic [8:0]                  reps;
    logic [8:0]                  rep_inc;

    logic [lmss_pkg::TICK_W-1:0] n_tick;
    logic                        n_phase;
    logic [lmss_pkg::ROW_W-1:0]  n_row;
    logic [7:0]                  n_rep_idx;
    logic [AW-1:0]               n_offset;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_len   <= lmss_pkg::RST_FRAME_LEN;
            r_long_dwell  <= lmss_pkg::RST_LONG_DWELL;
            r_short_dwell <= lmss_pkg::RST_SHORT_DWELL;
            r_repeat      <= lmss_pkg::RST_REPEAT;
        end else if (cfg_wr) begin
            unique case (lmss_pkg::t_reg_idx'(paddr[3:2]))
                lmss_pkg::REG_FRAME_LEN:   r_frame_len   <= pwdata[7:0];
                lmss_pkg::REG_LONG_DWELL:  r_long_dwell  <= pwdata[15:0];
                lmss_pkg::REG_SHORT_DWELL: r_short_dwell <= pwdata[15:0];
                lmss_pkg::REG_REPEAT:      r_repeat      <= pwdata[7:0];
            endcase
        end
    end

    always_comb begin
        unique case (lmss_pkg::t_reg_idx'(paddr[3:2]))
            lmss_pkg::REG_FRAME_LEN:   prdata = {24'd0, r_frame_len};
            lmss_pkg::REG_LONG_DWELL:  prdata = {16'd0, r_long_dwell};
            lmss_pkg::REG_SHORT_DWELL: prdata = {16'd0, r_short_dwell};
            lmss_pkg::REG_REPEAT:      prdata = {24'd0, r_repeat};
        endcase
    end

    // ---------------- input handshake ----------------
    assign s1_adv          = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_s1_valid || s1_adv;
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign tick_acc        = in_acc && !i_s_axis_tuser;
    assign tick_load       = tick_acc && (r_tick == '0);
    assign wr_index        = i_s_axis_tdata[6:0];
    assign wr_value        = i_s_axis_tdata[22:7];
    assign wr_acc          = in_acc && i_s_axis_tuser && (32'(wr_index) < FRAME_DEPTH);

    // ---------------- frame store ----------------
    // offsets never pass the frame length minus the scan span, so no wrap
    assign addr_a = AW'(r_offset) + AW'(r_row);
    assign addr_b = addr_a + AW'(lmss_pkg::COL_STEP);
    assign addr_c = addr_a + AW'(2 * lmss_pkg::COL_STEP);
    assign raddr0 = tick_load ? addr_a : r_addr_c;

    lmss_frame_store #(
        .FRAME_DEPTH (FRAME_DEPTH),
        .AW          (AW)
    ) u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_we     (wr_acc),
        .i_waddr  (AW'(wr_index)),
        .i_wdata  (wr_value),
        .i_raddr0 (raddr0),
        .i_raddr1 (addr_b),
        .o_rdata0 (rdata0),
        .o_rdata1 (rdata1)
    );

    // ---------------- scan counters ----------------
    assign dwell    = r_phase ? r_short_dwell : r_long_dwell;
    assign send_end = r_tick >= (lmss_pkg::SHIFT_TICKS + lmss_pkg::TICK_W'(dwell));

    assign len        = ({1'b0, r_frame_len} > lmss_pkg::LEN_W'(FRAME_DEPTH))
                      ? lmss_pkg::LEN_W'(FRAME_DEPTH) : {1'b0, r_frame_len};
    assign last       = (len >= lmss_pkg::LEN_W'(lmss_pkg::SCAN_SPAN))
                      ? len - lmss_pkg::LEN_W'(lmss_pkg::SCAN_SPAN) : '0;
    assign offset_inc = lmss_pkg::LEN_W'(r_offset) + lmss_pkg::LEN_W'(1);
    assign reps       = (r_repeat == '0) ? 9'd1 : {1'b0, r_repeat};
    assign rep_inc    = {1'b0, r_rep_idx} + 9'd1;

    always_comb begin
        n_tick    = r_tick + lmss_pkg::TICK_W'(1);
        n_phase   = r_phase;
        n_row     = r_row;
        n_rep_idx = r_rep_idx;
        n_offset  = r_offset;
        if (send_end) begin
            n_tick = '0;
            if (!r_phase) begin
                n_phase = 1'b1;
            end else begin
                n_phase = 1'b0;
                n_row   = r_row + lmss_pkg::ROW_W'(1);
                if (r_row == lmss_pkg::ROW_W'(lmss_pkg::ROWS - 1)) begin
                    if (rep_inc < reps) begin
                        n_rep_idx = rep_inc[7:0];
                    end else begin
                        n_rep_idx = '0;
                        n_offset  = (offset_inc > last) ? '0 : AW'(offset_inc);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick    <= '0;
            r_phase   <= 1'b0;
            r_row     <= '0;
            r_rep_idx <= '0;
            r_offset  <= '0;
        end else if (tick_acc) begin
            r_tick    <= n_tick;
            r_phase   <= n_phase;
            r_row     <= n_row;
            r_rep_idx <= n_rep_idx;
            r_offset  <= n_offset;
        end
    end

    // ---------------- column fetch ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ld1 <= 1'b0;
            r_ld2 <= 1'b0;
        end else begin
            r_ld1 <= tick_load;
            r_ld2 <= r_ld1;
        end
    end

    assign mask      = r_ld_full ? lmss_pkg::MASK_ALL : lmss_pkg::MASK_ONE;
    // first column is taken straight from the read data in the cycle it lands
    assign col_a_cur = r_ld1 ? lmss_pkg::permute(rdata0 & mask) : r_col_a;

    always_ff @(posedge i_clk) begin
        if (tick_load) begin
            r_ld_full <= r_phase;
            r_addr_c  <= addr_c;
            r_anode   <= lmss_pkg::anode(r_row);
        end
        if (r_ld1) begin
            r_col_a <= lmss_pkg::permute(rdata0 & mask);
            r_col_b <= lmss_pkg::permute(rdata1 & mask);
        end
        if (r_ld2) begin
            r_col_c <= lmss_pkg::permute(rdata0 & mask);
        end
    end

    // ---------------- pipeline ----------------
    assign word    = {r_anode, r_col_c, r_col_b, col_a_cur};
    assign s1_data = r_s1_shift && word[r_s1_bit];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_axis_tready) begin
                r_s1_valid <= tick_acc;
            end
            if (s1_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (tick_acc) begin
            r_s1_shift <= r_tick < lmss_pkg::SHIFT_TICKS;
            r_s1_sclk  <= (r_tick < lmss_pkg::SHIFT_TICKS) && r_tick[0];
            r_s1_latch <= r_tick == lmss_pkg::SHIFT_TICKS;
            r_s1_bit   <= r_tick[lmss_pkg::BIT_IDX_W:1];
        end
        if (s1_adv && r_s1_valid) begin
            r_out_data <= {r_s1_latch, r_s1_sclk, s1_data};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'd0, r_out_data};

    // ---------------- assertions ----------------
    `LMSS_ASSERT_NEXT(a_fetch_seq, r_ld1, r_ld2, "column fetch skipped a read")
    `LMSS_ASSERT_SAME(a_no_overlap, tick_load, !(r_s1_valid && r_s1_shift), "reload mid shift")
    `LMSS_ASSERT_SAME(a_pin_excl, r_out_valid, !(r_out_data[1] && r_out_data[2]), "sclk with latch")

endmodule

[verif/tb_led_matrix_scroll_scanner_unit.sv]
// ----------------------------------------------------------------------------
// tb_led_matrix_scroll_scanner_unit
// self-checking bench for the scrolling led matrix scanner: a clocked driver
// feeds tick and column-write transactions from a queue, a scan predictor
// works out the pin levels of every tick, and a clocked monitor compares each
// result transaction with the oldest prediction under random stalls
// ----------------------------------------------------------------------------
module tb_led_matrix_scroll_scanner_unit;

    localparam int FRAME_DEPTH = lmss_pkg::FRAME_DEPTH_DEF;
    localparam int AW = $clog2(FRAME_DEPTH);
    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;
    localparam int ERR_SHOWN = 40;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 10;

    typedef struct packed {
        logic        kind;
        logic [6:0]  idx;
        logic [15:0] val;
    } t_scan_item;

    typedef struct packed {
        logic data;
        logic sclk;
        logic latch;
    } t_pins;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [23:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tready = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    wire         o_s_axis_tready;
    wire         o_m_axis_tvalid;
    wire  [7:0]  o_m_axis_tdata;
    wire  [31:0] prdata;
    wire         pready;

    led_matrix_scroll_scanner_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #5 i_clk = ~i_clk;

    // scan predictor state and its copy of the registers
    logic [15:0] frame_mem [FRAME_DEPTH];
    logic [55:0] shift_reg = '0;
    int unsigned scroll_pos = 0;
    int unsigned rep_pos = 0;
    int unsigned row_pos = 0;
    int unsigned tick_pos = 0;
    logic        hue_full = 1'b0;
    logic [7:0]  cfg_frame_len = lmss_pkg::RST_FRAME_LEN;
    logic [15:0] cfg_long_dwell = lmss_pkg::RST_LONG_DWELL;
    logic [15:0] cfg_short_dwell = lmss_pkg::RST_SHORT_DWELL;
    logic [7:0]  cfg_repeat = lmss_pkg::RST_REPEAT;

    t_scan_item scan_items [$];
    t_pins      pin_expect [$];
    t_scan_item on_bus;

    int tx_idle_pct = 25;
    int rx_idle_pct = 65;
    int rx_hold_reqs = 0;
    int rx_hold_done = 0;
    int rx_hold_left = 0;
    int err_cnt = 0;
    int n_ticks = 0;
    int n_writes = 0;
    int n_checked = 0;
    int n_sends = 0;
    int n_row_scans = 0;
    int n_wraps = 0;

    // board wiring: low byte lands on odd bits, high byte on even, active low
    function automatic logic [15:0] wire_column(input logic [15:0] word);
        logic [15:0] r;
        r = '0;
        for (int b = 0; b < 16; b++) begin
            r[4'(2 * ((b + 4) % 8) + (b < 8 ? 1 : 0))] = word[b];
        end
        return ~r;
    endfunction

    function automatic t_pins scan_tick();
        t_pins p;
        logic [15:0] mask;
        logic [2:0] row;
        logic [7:0] an;
        logic [AW-1:0] ia;
        logic [AW-1:0] ib;
        logic [AW-1:0] ic;
        int unsigned base;
        int unsigned dwell;
        int unsigned span;
        int unsigned last_pos;
        int unsigned reps;
        if (tick_pos == 0) begin
            mask = hue_full ? lmss_pkg::MASK_ALL : lmss_pkg::MASK_ONE;
            row = row_pos[2:0];
            base = row_pos + scroll_pos;
            an = '0;
            an[3'(6 - 2 * row[1:0] + row[2])] = 1'b1;
            ia = AW'(base % FRAME_DEPTH);
            ib = AW'((base + lmss_pkg::COL_STEP) % FRAME_DEPTH);
            ic = AW'((base + 2 * lmss_pkg::COL_STEP) % FRAME_DEPTH);
            shift_reg = {an,
                         wire_column(frame_mem[ic] & mask),
                         wire_column(frame_mem[ib] & mask),
                         wire_column(frame_mem[ia] & mask)};
        end
        p.data = shift_reg[0];
        p.sclk = 1'b0;
        p.latch = 1'b0;
        if (tick_pos < 32'(lmss_pkg::SHIFT_TICKS)) begin
            p.sclk = tick_pos[0];
            if (p.sclk) shift_reg = shift_reg >> 1;
        end else if (tick_pos == 32'(lmss_pkg::SHIFT_TICKS)) begin
            p.latch = 1'b1;
        end
        dwell = 32'(hue_full ? cfg_short_dwell : cfg_long_dwell);
        if (tick_pos < 32'(lmss_pkg::SHIFT_TICKS) + dwell) begin
            tick_pos++;
            return p;
        end
        // send finished: step colour, row, repeat and scroll
        tick_pos = 0;
        n_sends++;
        hue_full = ~hue_full;
        if (hue_full) return p;
        row_pos++;
        if (row_pos < lmss_pkg::ROWS) return p;
        row_pos = 0;
        n_row_scans++;
        reps = (cfg_repeat == '0) ? 1 : 32'(cfg_repeat);
        rep_pos++;
        if (rep_pos < reps) return p;
        rep_pos = 0;
        span = (32'(cfg_frame_len) > FRAME_DEPTH) ? FRAME_DEPTH : 32'(cfg_frame_len);
        last_pos = (span >= lmss_pkg::SCAN_SPAN) ? span - lmss_pkg::SCAN_SPAN : 0;
        scroll_pos++;
        if (scroll_pos > last_pos) begin
            scroll_pos = 0;
            n_wraps++;
        end
        return p;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            for (int i = 0; i < FRAME_DEPTH; i++) begin
                frame_mem[i] = '0;
            end
        end else begin
            if (s_tvalid && o_s_axis_tready) begin
                if (on_bus.kind == KIND_WRITE) begin
                    if (on_bus.idx < FRAME_DEPTH) frame_mem[on_bus.idx] = on_bus.val;
                    n_writes++;
                end else begin
                    pin_expect.push_back(scan_tick());
                    n_ticks++;
                end
            end
            if (!s_tvalid || o_s_axis_tready) begin
                if (scan_items.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    on_bus = scan_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {1'b0, on_bus.val, on_bus.idx};
                    s_tuser <= on_bus.kind;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    function automatic void check_pin(input string name, input logic want, input logic got);
        if (got !== want) begin
            err_cnt++;
            if (err_cnt <= ERR_SHOWN) begin
                $display("%0t: %s mismatch, expected %b actual %b", $time, name, want, got);
            end
        end
    endfunction

    // monitor
    always @(posedge i_clk) begin
        t_pins want;
        if (i_rst_n && o_m_axis_tvalid && m_tready) begin
            if (pin_expect.size() == 0) begin
                err_cnt++;
                if (err_cnt <= ERR_SHOWN) begin
                    $display("%0t: unexpected result, expected none actual %b", $time,
                             o_m_axis_tdata[2:0]);
                end
            end else begin
                want = pin_expect.pop_front();
                check_pin("serial_data", want.data, o_m_axis_tdata[0]);
                check_pin("shift_clock", want.sclk, o_m_axis_tdata[1]);
                check_pin("latch_clock", want.latch, o_m_axis_tdata[2]);
                n_checked++;
            end
        end
        if (rx_hold_done != rx_hold_reqs) begin
            rx_hold_done = rx_hold_reqs;
            rx_hold_left = RX_HOLD_CYCLES;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic write_reg(input lmss_pkg::t_reg_idx idx, input logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        while (scan_items.size() != 0 || s_tvalid || pin_expect.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic set_scan_config(input logic [7:0] len, input logic [15:0] ld,
                                   input logic [15:0] sd, input logic [7:0] rep);
        wait_drained();
        // writes leave no result behind, so let the pipeline empty
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        write_reg(lmss_pkg::REG_FRAME_LEN, {24'd0, len});
        write_reg(lmss_pkg::REG_LONG_DWELL, {16'd0, ld});
        write_reg(lmss_pkg::REG_SHORT_DWELL, {16'd0, sd});
        write_reg(lmss_pkg::REG_REPEAT, {24'd0, rep});
        cfg_frame_len = len;
        cfg_long_dwell = ld;
        cfg_short_dwell = sd;
        cfg_repeat = rep;
    endtask

    task automatic set_idle(input int tx, input int rx);
        @(negedge i_clk);
        tx_idle_pct = tx;
        rx_idle_pct = rx;
    endtask

    task automatic push_item(input logic kind, input logic [6:0] idx, input logic [15:0] val);
        t_scan_item it;
        it.kind = kind;
        it.idx = idx;
        it.val = val;
        scan_items.push_back(it);
    endtask

    task automatic push_random(input int n, input int write_pct);
        t_scan_item it;
        @(negedge i_clk);
        for (int i = 0; i < n; i++) begin
            it.kind = ($urandom_range(99) < write_pct) ? KIND_WRITE : KIND_TICK;
            // half the writes land on the low 32 columns, where a short frame lies
            it.idx = $urandom_range(1) ? 7'($urandom_range(31)) : 7'($urandom_range(127));
            case ($urandom_range(3))
                0: it.val = 16'h0000;
                1: it.val = 16'hffff;
                default: it.val = 16'($urandom);
            endcase
            scan_items.push_back(it);
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: writes right before and right after a load
        @(negedge i_clk);
        push_item(KIND_WRITE, 7'd0, 16'hffff);
        push_item(KIND_WRITE, 7'd127, 16'hffff);
        push_item(KIND_WRITE, 7'd8, 16'h0000);
        push_item(KIND_WRITE, 7'd16, 16'h8001);
        push_item(KIND_TICK, 7'd0, 16'h0000);
        push_item(KIND_WRITE, 7'd16, 16'h7ffe);
        push_item(KIND_WRITE, 7'd8, 16'hffff);
        push_item(KIND_TICK, 7'd127, 16'hffff);
        push_item(KIND_WRITE, 7'd1, 16'h5a5a);
        for (int i = 0; i < 15; i++) begin
            push_item(KIND_TICK, 7'd0, 16'h0000);
        end

        // short dwells, zero repeat count, sender idle 25 receiver 65
        set_scan_config(8'd25, 16'd2, 16'd0, 8'd0);
        set_idle(25, 65);
        push_random(150, 20);

        // frame shorter than one screen, then a second batch once the first has drained
        set_scan_config(8'd0, 16'd0, 16'd1, 8'd1);
        set_idle(65, 25);
        push_random(80, 20);
        wait_drained();
        push_random(80, 20);

        // oversize frame, maximum repeats, long receiver hold-off
        set_scan_config(8'd255, 16'd0, 16'd0, 8'd255);
        set_idle(0, 0);
        push_random(120, 20);
        @(negedge i_clk);
        rx_hold_reqs++;

        // two-offset frame with a zero long dwell
        set_scan_config(8'd25, 16'd0, 16'd1, 8'd2);
        push_random(50, 10);

        // longest dwells
        set_scan_config(8'd128, 16'hffff, 16'hffff, 8'd8);
        push_random(40, 5);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("ran %0d ticks and %0d column writes, %0d pin results checked",
                 n_ticks, n_writes, n_checked);
        $display("%0d sends latched, %0d row scans, %0d offset wraps",
                 n_sends, n_row_scans, n_wraps);
        if (err_cnt == 0) begin
            $display("led_matrix_scroll_scanner_unit regression: pass");
        end else begin
            $display("led_matrix_scroll_scanner_unit regression: fail");
        end
        $finish;
    end

    initial begin
        #8000000;
        $display("timeout waiting for results");
        $display("led_matrix_scroll_scanner_unit regression: fail");
        $finish;
    end

endmodule

[led_matrix_scroll_scanner_unit.f]
+incdir+rtl
rtl/lmss_pkg.sv
rtl/lmss_frame_store.sv
rtl/led_matrix_scroll_scanner_unit.sv
verif/tb_led_matrix_scroll_scanner_unit.sv
